@@ hw/rtl/acd_pkg.sv @@
// ----------------------------------------------------------------------------
// acd_pkg: shared types and constants of the acquisition command decoder
// Action codes, command byte codes, rates and the small layout tables.
// ----------------------------------------------------------------------------
package acd_pkg;

	// action reported with each result item
	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_BATTERY   = 4'd1,
		ACT_ARM_START = 4'd2,
		ACT_START     = 4'd3,
		ACT_PWM       = 4'd4,
		ACT_OUTPUTS   = 4'd5,
		ACT_RATE      = 4'd6,
		ACT_VERSION   = 4'd7,
		ACT_STATUS    = 4'd8,
		ACT_STOP      = 4'd9
	} action_t;

	// host event kind
	localparam logic FUNC_BYTE       = 1'b0;
	localparam logic FUNC_DISCONNECT = 1'b1;

	// command byte codes and masks
	localparam logic [7:0] MASK_ANY_MODE  = 8'hA3;
	localparam logic [7:0] MASK_SUB       = 8'hF3;
	localparam logic [7:0] CMD_PWM_ARM    = 8'hA3;
	localparam logic [7:0] CMD_OUTPUTS    = 8'hB3;
	localparam logic [7:0] CMD_RATE_8K    = 8'hE3;
	localparam logic [7:0] CMD_STOP_A     = 8'h00;
	localparam logic [7:0] CMD_STOP_B     = 8'hFF;
	localparam logic [7:0] CMD_VERSION_A  = 8'h07;
	localparam logic [7:0] CMD_VERSION_B  = 8'h0F;
	localparam logic [7:0] CMD_STATUS     = 8'h0B;
	localparam logic [7:0] CMD_RATE_DEC1K = 8'h03;
	localparam logic [7:0] CMD_RATE_DEC100 = 8'h23;
	localparam logic [7:0] CMD_RATE_DEC10 = 8'h43;
	localparam logic [7:0] CMD_RATE_1K    = 8'h63;
	localparam logic [7:0] CMD_RATE_2K    = 8'h83;
	localparam logic [7:0] CMD_RATE_4K    = 8'hC3;

	// low two bits of an idle-mode command
	localparam logic [1:0] SUB_THRESHOLD  = 2'd0;
	localparam logic [1:0] SUB_START_LIVE = 2'd1;
	localparam logic [1:0] SUB_START_SIM  = 2'd2;

	// converter rates and decimation counts
	localparam logic [12:0] HZ_1000 = 13'd1000;
	localparam logic [12:0] HZ_2000 = 13'd2000;
	localparam logic [12:0] HZ_4000 = 13'd4000;
	localparam logic [12:0] HZ_8000 = 13'd8000;
	localparam logic [9:0]  DEC_NONE = 10'd0;
	localparam logic [9:0]  DEC_1000 = 10'd1000;
	localparam logic [9:0]  DEC_100  = 10'd100;
	localparam logic [9:0]  DEC_10   = 10'd10;

	localparam logic [9:0]  BATTERY_BASE_RST = 10'd527;
	localparam logic [10:0] THRESHOLD_RST    = 11'd527;

	localparam int NUM_ANALOG = 6;

	// physical channel of each analog input in live mode
	localparam logic [2:0] CHAN_MAP [NUM_ANALOG] = '{3'd0, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5};

	// extra bytes per frame for the extra converter channels
	localparam logic [3:0] EXT_ONE_BYTES  = 4'd3;
	localparam logic [3:0] EXT_BOTH_BYTES = 4'd6;
	localparam logic [1:0] EXT_BOTH       = 2'd3;
	localparam logic [1:0] EXT_NONE       = 2'd0;

	// analog part of the frame length, ceiling of the packed bit count
	function automatic logic [3:0] frame_base(input logic [2:0] n);
		logic [3:0] fb;
		case (n)
			3'd0:    fb = 4'd2;
			3'd1:    fb = 4'd3;
			3'd2:    fb = 4'd4;
			3'd3:    fb = 4'd6;
			3'd4:    fb = 4'd7;
			3'd5:    fb = 4'd8;
			3'd6:    fb = 4'd8;
			default: fb = 4'd0;
		endcase
		return fb;
	endfunction

	// frame start slot from the channel count
	function automatic logic [2:0] start_slot_of(input logic [2:0] n);
		logic [2:0] s;
		s = 3'd6 - n;
		if (n inside {[3'd3:3'd5]})
			s = s - 3'd1;
		return s;
	endfunction

endpackage

@@ hw/rtl/acd_if.sv @@
// ----------------------------------------------------------------------------
// acd_if: item channels of the acquisition command decoder
// Valid/ready channels for host events and for decoded result items.
// ----------------------------------------------------------------------------
interface acd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] cmd_byte;

	modport source (output valid, output func, output cmd_byte, input ready);
	modport sink   (input valid, input func, input cmd_byte, output ready);
endinterface

interface acd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [7:0]  value_byte;
	logic [10:0] battery_threshold;
	logic [12:0] converter_rate_hz;
	logic [9:0]  decimation;
	logic [17:0] channel_list;
	logic [2:0]  analog_count;
	logic [2:0]  start_slot;
	logic [3:0]  frame_bytes;
	logic [1:0]  ext_mask;
	logic        simulated_out;

	modport source (
		output valid, output action, output value_byte, output battery_threshold,
		output converter_rate_hz, output decimation, output channel_list,
		output analog_count, output start_slot, output frame_bytes,
		output ext_mask, output simulated_out, input ready
	);
	modport sink (
		input valid, input action, input value_byte, input battery_threshold,
		input converter_rate_hz, input decimation, input channel_list,
		input analog_count, input start_slot, input frame_bytes,
		input ext_mask, input simulated_out, output ready
	);
endinterface

@@ hw/rtl/acquisition_command_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// acquisition_command_decoder_unit: host command byte decoder
// Turns host command bytes and disconnect events into one action item each.
// ----------------------------------------------------------------------------
// Each accepted item (a command byte or a host disconnect) yields exactly one
// result item, in order. The block is a two-register pipeline: the item is
// captured in an input register, then decoded against the mode flags into the
// result register, so it sustains one item per cycle while the output is not
// stalled. A stalled result holds while one more item waits in the input
// register. battery_base may be written at any time while idle and affects
// only later threshold commands; the mode state, battery base and valid flags
// return to their reset values on arst_n, but the data registers are not reset.
module acquisition_command_decoder_unit
	import acd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	acd_in_if.sink     cmd,
	acd_out_if.source  res,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata
);

	// result item held in the output register
	typedef struct packed {
		action_t     action;
		logic [7:0]  value_byte;
		logic [10:0] battery_threshold;
		logic [12:0] converter_rate_hz;
		logic [9:0]  decimation;
		logic [17:0] channel_list;
		logic [2:0]  analog_count;
		logic [2:0]  start_slot;
		logic [3:0]  frame_bytes;
		logic [1:0]  ext_mask;
		logic        simulated_out;
	} result_t;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       res_valid_s2;
	result_t    res_s2;
	logic       advance_s1;

	logic [9:0]  battery_base_q;
	logic        await_ch_q;
	logic        await_pwm_q;
	logic        running_q;
	logic        sim_q;
	logic [9:0]  dec_q;
	logic [10:0] thr_q;

	logic        await_ch_n;
	logic        await_pwm_n;
	logic        running_n;
	logic        sim_n;
	logic [9:0]  dec_n;
	logic [10:0] thr_n;
	result_t     res_n;

	logic [17:0] list_c;
	logic [2:0]  count_c;
	logic [2:0]  chan_c;
	logic [1:0]  ext_c;
	logic [3:0]  fb_c;

	// pipeline moves when the output register is free or being emptied
	assign advance_s1 = !res_valid_s2 || res.ready;
	assign cmd.ready  = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			func_s1 <= cmd.func;
			byte_s1 <= cmd.cmd_byte;
		end
	end

	// channel layout of a start command
	always_comb begin
		list_c  = '0;
		count_c = '0;
		chan_c  = '0;
		for (int i = 0; i < NUM_ANALOG; i++) begin
			if (byte_s1[i]) begin
				chan_c  = sim_q ? 3'(i) : CHAN_MAP[i];
				list_c  = list_c | (18'(chan_c) << (5'(count_c) * 5'd3));
				count_c = count_c + 3'd1;
			end
		end
		ext_c = byte_s1[7:6];
		fb_c  = frame_base(count_c);
		if (ext_c == EXT_BOTH)
			fb_c = fb_c + EXT_BOTH_BYTES;
		else if (ext_c != EXT_NONE)
			fb_c = fb_c + EXT_ONE_BYTES;
	end

	// command decode against the current mode
	always_comb begin
		await_ch_n  = await_ch_q;
		await_pwm_n = await_pwm_q;
		running_n   = running_q;
		sim_n       = sim_q;
		dec_n       = dec_q;
		thr_n       = thr_q;
		res_n       = '0;
		res_n.action = ACT_NONE;
		if (func_s1 == FUNC_DISCONNECT) begin
			if (running_q) begin
				running_n    = 1'b0;
				dec_n        = DEC_NONE;
				res_n.action = ACT_STOP;
			end
		end else if (await_ch_q) begin
			await_ch_n          = 1'b0;
			running_n           = 1'b1;
			res_n.action        = ACT_START;
			res_n.channel_list  = list_c;
			res_n.analog_count  = count_c;
			res_n.start_slot    = start_slot_of(count_c);
			res_n.frame_bytes   = fb_c;
			res_n.ext_mask      = ext_c;
			res_n.simulated_out = sim_q;
		end else if (await_pwm_q) begin
			await_pwm_n      = 1'b0;
			res_n.action     = ACT_PWM;
			res_n.value_byte = byte_s1;
		end else if ((byte_s1 & MASK_ANY_MODE) == MASK_ANY_MODE && byte_s1 != CMD_STOP_B) begin
			if (byte_s1 == CMD_PWM_ARM) begin
				await_pwm_n = 1'b1;
			end else if ((byte_s1 & MASK_SUB) == CMD_OUTPUTS) begin
				res_n.action     = ACT_OUTPUTS;
				res_n.value_byte = byte_s1;
			end else if ((byte_s1 & MASK_SUB) == CMD_RATE_8K) begin
				dec_n                   = DEC_NONE;
				res_n.action            = ACT_RATE;
				res_n.converter_rate_hz = HZ_8000;
			end
		end else if (!running_q) begin
			case (byte_s1[1:0])
				SUB_THRESHOLD: begin
					thr_n        = {1'b0, battery_base_q} + {5'b0, byte_s1[7:2]};
					res_n.action = ACT_BATTERY;
				end
				SUB_START_LIVE, SUB_START_SIM: begin
					sim_n        = (byte_s1[1:0] == SUB_START_SIM);
					await_ch_n   = 1'b1;
					res_n.action = ACT_ARM_START;
				end
				default: begin
					case (byte_s1)
						CMD_VERSION_A, CMD_VERSION_B: res_n.action = ACT_VERSION;
						CMD_STATUS: res_n.action = ACT_STATUS;
						CMD_RATE_DEC1K: begin
							dec_n = DEC_1000;
							res_n.action = ACT_RATE;
							res_n.converter_rate_hz = HZ_1000;
						end
						CMD_RATE_DEC100: begin
							dec_n = DEC_100;
							res_n.action = ACT_RATE;
							res_n.converter_rate_hz = HZ_1000;
						end
						CMD_RATE_DEC10: begin
							dec_n = DEC_10;
							res_n.action = ACT_RATE;
							res_n.converter_rate_hz = HZ_1000;
						end
						CMD_RATE_1K: begin
							dec_n = DEC_NONE;
							res_n.action = ACT_RATE;
							res_n.converter_rate_hz = HZ_1000;
						end
						CMD_RATE_2K: begin
							dec_n = DEC_NONE;
							res_n.action = ACT_RATE;
							res_n.converter_rate_hz = HZ_2000;
						end
						CMD_RATE_4K: begin
							dec_n = DEC_NONE;
							res_n.action = ACT_RATE;
							res_n.converter_rate_hz = HZ_4000;
						end
						default: res_n.action = ACT_NONE;
					endcase
				end
			endcase
		end else if (byte_s1 == CMD_STOP_A || byte_s1 == CMD_STOP_B) begin
			running_n    = 1'b0;
			dec_n        = DEC_NONE;
			res_n.action = ACT_STOP;
		end
		res_n.battery_threshold = thr_n;
		res_n.decimation        = dec_n;
	end

	// mode state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_base_q <= BATTERY_BASE_RST;
			await_ch_q     <= 1'b0;
			await_pwm_q    <= 1'b0;
			running_q      <= 1'b0;
			sim_q          <= 1'b0;
			dec_q          <= DEC_NONE;
			thr_q          <= THRESHOLD_RST;
		end else begin
			if (cfg_we)
				battery_base_q <= cfg_wdata;
			if (valid_s1 && advance_s1) begin
				await_ch_q  <= await_ch_n;
				await_pwm_q <= await_pwm_n;
				running_q   <= running_n;
				sim_q       <= sim_n;
				dec_q       <= dec_n;
				thr_q       <= thr_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			res_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1)
			res_s2 <= res_n;
	end

	// output channel
	assign res.valid             = res_valid_s2;
	assign res.action            = res_s2.action;
	assign res.value_byte        = res_s2.value_byte;
	assign res.battery_threshold = res_s2.battery_threshold;
	assign res.converter_rate_hz = res_s2.converter_rate_hz;
	assign res.decimation        = res_s2.decimation;
	assign res.channel_list      = res_s2.channel_list;
	assign res.analog_count      = res_s2.analog_count;
	assign res.start_slot        = res_s2.start_slot;
	assign res.frame_bytes       = res_s2.frame_bytes;
	assign res.ext_mask          = res_s2.ext_mask;
	assign res.simulated_out     = res_s2.simulated_out;

endmodule

@@ verif/acd_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// acd_decoder_checker: result predictor and scoreboard for the command decoder
// Watches the command and result channels and the battery base port. Every
// accepted command item is decoded against a private copy of the decoder state,
// and the outcome is queued. Each accepted result item is compared field by
// field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module acd_decoder_checker
	import acd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	acd_in_if          cmd,
	acd_out_if         res,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	output int         fail_count,
	output int         n_pending,
	output int         n_checked,
	output logic [9:0] actions_seen
);

	typedef struct packed {
		action_t     action;
		logic [7:0]  value_byte;
		logic [10:0] battery_threshold;
		logic [12:0] converter_rate_hz;
		logic [9:0]  decimation;
		logic [17:0] channel_list;
		logic [2:0]  analog_count;
		logic [2:0]  start_slot;
		logic [3:0]  frame_bytes;
		logic [1:0]  ext_mask;
		logic        simulated_out;
	} decoded_cmd_t;

	// shadow copy of the decoder state
	logic [9:0]  base_q;
	logic        await_layout;
	logic        await_duty;
	logic        running_q;
	logic        sim_mode;
	logic [9:0]  dec_count;
	logic [10:0] threshold_q;

	decoded_cmd_t pending_q [$];

	// decode one host event and advance the shadow state
	function automatic decoded_cmd_t decode_event(input logic f, input logic [7:0] b);
		decoded_cmd_t r;
		int           n;
		int           i;
		logic [2:0]   ch;
		logic         rate_hit;
		logic [12:0]  hz;
		logic [9:0]   dec;
		r        = '0;
		rate_hit = 1'b0;
		hz       = '0;
		dec      = DEC_NONE;
		if (f == FUNC_DISCONNECT) begin
			if (running_q) begin
				running_q = 1'b0;
				dec_count = DEC_NONE;
				r.action  = ACT_STOP;
			end
		end else if (await_layout) begin
			// channel layout byte: pack enabled channels, low bits first
			await_layout = 1'b0;
			n = 0;
			for (i = 0; i < NUM_ANALOG; i++) begin
				if (b[i]) begin
					ch = sim_mode ? 3'(i) : CHAN_MAP[i];
					r.channel_list = r.channel_list | (18'(ch) << (3 * n));
					n++;
				end
			end
			r.analog_count = 3'(n);
			r.start_slot   = 3'(6 - n - ((n >= 3 && n <= 5) ? 1 : 0));
			if (n <= 4)
				r.frame_bytes = 4'((12 + 10 * n + 7) / 8);
			else
				r.frame_bytes = 4'((52 + 6 * (n - 4) + 7) / 8);
			r.ext_mask = b[7:6];
			if (r.ext_mask == EXT_BOTH)
				r.frame_bytes = r.frame_bytes + EXT_BOTH_BYTES;
			else if (r.ext_mask != EXT_NONE)
				r.frame_bytes = r.frame_bytes + EXT_ONE_BYTES;
			r.simulated_out = sim_mode;
			running_q       = 1'b1;
			r.action        = ACT_START;
		end else if (await_duty) begin
			await_duty   = 1'b0;
			r.action     = ACT_PWM;
			r.value_byte = b;
		end else if ((b & MASK_ANY_MODE) == MASK_ANY_MODE && b != CMD_STOP_B) begin
			// commands taken in either mode
			if (b == CMD_PWM_ARM) begin
				await_duty = 1'b1;
			end else if ((b & MASK_SUB) == CMD_OUTPUTS) begin
				r.action     = ACT_OUTPUTS;
				r.value_byte = b;
			end else if ((b & MASK_SUB) == CMD_RATE_8K) begin
				rate_hit = 1'b1;
				hz       = HZ_8000;
			end
		end else if (!running_q) begin
			case (b[1:0])
				SUB_THRESHOLD: begin
					threshold_q = {1'b0, base_q} + 11'(b[7:2]);
					r.action    = ACT_BATTERY;
				end
				SUB_START_LIVE, SUB_START_SIM: begin
					sim_mode     = (b[1:0] == SUB_START_SIM);
					await_layout = 1'b1;
					r.action     = ACT_ARM_START;
				end
				default: begin
					case (b)
						CMD_VERSION_A, CMD_VERSION_B: r.action = ACT_VERSION;
						CMD_STATUS: r.action = ACT_STATUS;
						CMD_RATE_DEC1K: begin
							rate_hit = 1'b1; hz = HZ_1000; dec = DEC_1000;
						end
						CMD_RATE_DEC100: begin
							rate_hit = 1'b1; hz = HZ_1000; dec = DEC_100;
						end
						CMD_RATE_DEC10: begin
							rate_hit = 1'b1; hz = HZ_1000; dec = DEC_10;
						end
						CMD_RATE_1K: begin
							rate_hit = 1'b1; hz = HZ_1000;
						end
						CMD_RATE_2K: begin
							rate_hit = 1'b1; hz = HZ_2000;
						end
						CMD_RATE_4K: begin
							rate_hit = 1'b1; hz = HZ_4000;
						end
						default: ;
					endcase
				end
			endcase
		end else if (b == CMD_STOP_A || b == CMD_STOP_B) begin
			running_q = 1'b0;
			dec_count = DEC_NONE;
			r.action  = ACT_STOP;
		end
		if (rate_hit) begin
			dec_count           = dec;
			r.action            = ACT_RATE;
			r.converter_rate_hz = hz;
		end
		r.battery_threshold = threshold_q;
		r.decimation        = dec_count;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [17:0] want,
			input logic [17:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// compare retiring result items, then queue the outcome of a new command item
	always @(posedge clk or negedge arst_n) begin
		decoded_cmd_t want;
		if (!arst_n) begin
			base_q       = BATTERY_BASE_RST;
			await_layout = 1'b0;
			await_duty   = 1'b0;
			running_q    = 1'b0;
			sim_mode     = 1'b0;
			dec_count    = DEC_NONE;
			threshold_q  = THRESHOLD_RST;
			pending_q.delete();
			fail_count   = 0;
			n_pending    = 0;
			n_checked    = 0;
			actions_seen = '0;
		end else begin
			if (res.valid && res.ready) begin
				if (pending_q.size() == 0) begin
					$error("result item arrived with no command item outstanding");
					fail_count++;
				end else begin
					want = pending_q.pop_front();
					check_field("action", want.action, res.action);
					check_field("value_byte", want.value_byte, res.value_byte);
					check_field("battery_threshold", want.battery_threshold,
						res.battery_threshold);
					check_field("converter_rate_hz", want.converter_rate_hz,
						res.converter_rate_hz);
					check_field("decimation", want.decimation, res.decimation);
					check_field("channel_list", want.channel_list, res.channel_list);
					check_field("analog_count", want.analog_count, res.analog_count);
					check_field("start_slot", want.start_slot, res.start_slot);
					check_field("frame_bytes", want.frame_bytes, res.frame_bytes);
					check_field("ext_mask", want.ext_mask, res.ext_mask);
					check_field("simulated_out", want.simulated_out, res.simulated_out);
					actions_seen[want.action] = 1'b1;
					n_checked++;
				end
			end
			if (cfg_we)
				base_q = cfg_wdata;
			if (cmd.valid && cmd.ready)
				pending_q.push_back(decode_event(cmd.func, cmd.cmd_byte));
			n_pending = pending_q.size();
		end
	end

endmodule

@@ verif/acquisition_command_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// acquisition_command_decoder_unit_tb: top of the command decoder testbench
// Drives a directed set of command items, then random command sequences over
// several battery base settings, with random idling on both channels. A
// separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module acquisition_command_decoder_unit_tb
	import acd_pkg::*;
;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int NUM_PHASES   = 5;
	localparam int PHASE_ITEMS  = 305;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [9:0] cfg_wdata;
	logic       calm;
	int         cycles;
	int         n_sent;
	int         n_bases;
	int         fail_count;
	int         n_pending;
	int         n_checked;
	logic [9:0] actions_seen;

	acd_in_if  cmd_ch ();
	acd_out_if res_ch ();

	acquisition_command_decoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	acd_decoder_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.res          (res_ch),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.n_pending    (n_pending),
		.n_checked    (n_checked),
		.actions_seen (actions_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL acquisition_command_decoder_unit");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	// offer one command item and hold it until accepted; returns at a falling edge
	task automatic send_item(input logic f, input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 8) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.func     <= f;
		cmd_ch.cmd_byte <= b;
		do @(posedge clk); while (!cmd_ch.ready);
		n_sent++;
		@(negedge clk);
	endtask

	// drain, then write the battery base while the decoder is idle
	task automatic program_base(input logic [9:0] v);
		cmd_ch.valid <= 1'b0;
		wait (n_pending == 0);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		n_bases++;
	endtask

	// one command, or a short command sequence, sent while the decoder is idle
	task automatic send_idle_command();
		case ($urandom_range(0, 7))
			0: send_item(FUNC_BYTE, {6'($urandom), SUB_THRESHOLD});
			1: begin
				case ($urandom_range(0, 5))
					0: send_item(FUNC_BYTE, CMD_RATE_DEC1K);
					1: send_item(FUNC_BYTE, CMD_RATE_DEC100);
					2: send_item(FUNC_BYTE, CMD_RATE_DEC10);
					3: send_item(FUNC_BYTE, CMD_RATE_1K);
					4: send_item(FUNC_BYTE, CMD_RATE_2K);
					default: send_item(FUNC_BYTE, CMD_RATE_4K);
				endcase
			end
			2: send_item(FUNC_BYTE, $urandom_range(0, 1) ? CMD_VERSION_A : CMD_VERSION_B);
			3: send_item(FUNC_BYTE, CMD_STATUS);
			4: send_item(FUNC_BYTE, CMD_OUTPUTS | {4'd0, 2'($urandom), 2'd0});
			5: send_item(FUNC_BYTE, CMD_RATE_8K | {4'd0, 2'($urandom), 2'd0});
			6: begin
				send_item(FUNC_BYTE, CMD_PWM_ARM);
				send_item(FUNC_BYTE, 8'($urandom));
			end
			default: begin
				// arming survives a disconnect
				send_item(FUNC_BYTE, {6'($urandom), SUB_START_LIVE});
				send_item(FUNC_DISCONNECT, 8'($urandom));
				send_item(FUNC_BYTE, 8'($urandom));
				send_item(FUNC_BYTE, CMD_STOP_A);
			end
		endcase
	endtask

	// acquisition session: arm, layout, some traffic while running, then usually a stop
	task automatic send_session();
		int k;
		send_item(FUNC_BYTE, {6'($urandom),
			$urandom_range(0, 1) ? SUB_START_SIM : SUB_START_LIVE});
		send_item(FUNC_BYTE, 8'($urandom));
		repeat ($urandom_range(0, 5)) begin
			k = $urandom_range(0, 3);
			if (k == 0) begin
				send_item(FUNC_BYTE, CMD_PWM_ARM);
				send_item(FUNC_BYTE, 8'($urandom));
			end else if (k == 1) begin
				send_item(FUNC_BYTE, CMD_OUTPUTS | {4'd0, 2'($urandom), 2'd0});
			end else if (k == 2) begin
				send_item(FUNC_BYTE, CMD_RATE_8K | {4'd0, 2'($urandom), 2'd0});
			end else begin
				send_item(FUNC_BYTE, 8'($urandom));
			end
		end
		// most sessions end cleanly, a few are left running
		case ($urandom_range(0, 9))
			0, 1, 2: send_item(FUNC_BYTE, CMD_STOP_A);
			3, 4, 5: send_item(FUNC_BYTE, CMD_STOP_B);
			6, 7, 8: send_item(FUNC_DISCONNECT, 8'($urandom));
			default: ;
		endcase
	endtask

	// stimulus
	initial begin
		int p;
		int goal;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		calm            = 1'b0;
		n_sent          = 0;
		n_bases         = 0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.func     = FUNC_BYTE;
		cmd_ch.cmd_byte = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every command kind and the corner cases
		program_base(10'd1023);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, 8'hFC);
		send_item(FUNC_BYTE, CMD_VERSION_A);
		send_item(FUNC_BYTE, CMD_VERSION_B);
		send_item(FUNC_BYTE, CMD_STATUS);
		send_item(FUNC_BYTE, CMD_RATE_DEC1K);
		send_item(FUNC_BYTE, CMD_RATE_8K);
		send_item(FUNC_BYTE, CMD_RATE_DEC100);
		send_item(FUNC_BYTE, CMD_RATE_DEC10);
		send_item(FUNC_BYTE, CMD_RATE_1K);
		send_item(FUNC_BYTE, CMD_RATE_2K);
		send_item(FUNC_BYTE, CMD_RATE_4K);
		send_item(FUNC_BYTE, CMD_PWM_ARM);
		send_item(FUNC_DISCONNECT, 8'hFF);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, CMD_OUTPUTS);
		send_item(FUNC_BYTE, 8'hA7);
		send_item(FUNC_BYTE, CMD_STOP_B);
		send_item(FUNC_BYTE, 8'h01);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, CMD_PWM_ARM);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, CMD_STOP_A);
		send_item(FUNC_BYTE, 8'h02);
		send_item(FUNC_BYTE, 8'h3F);
		send_item(FUNC_DISCONNECT, 8'h00);

		// random phases, one battery base each
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: program_base(10'd0);
				1: program_base(BATTERY_BASE_RST);
				3: program_base(10'd1023);
				default: program_base(10'($urandom));
			endcase
			calm = (p == 2);
			goal = n_sent + PHASE_ITEMS;
			while (n_sent < goal) begin
				case ($urandom_range(0, 99)) inside
					[0:44]:  send_session();
					[45:79]: send_idle_command();
					default: begin
						if ($urandom_range(0, 3) == 0)
							send_item(FUNC_DISCONNECT, 8'($urandom));
						else
							send_item(FUNC_BYTE, 8'($urandom));
					end
				endcase
			end
		end
		calm = 1'b0;

		// drain and give the verdict
		cmd_ch.valid <= 1'b0;
		wait (n_pending == 0);
		repeat (4) @(posedge clk);
		$display("sent %0d command items and checked %0d result items", n_sent, n_checked);
		$display("battery base settings: %0d, actions seen (bit per code): %b",
			n_bases, actions_seen);
		if (fail_count == 0)
			$display("PASS acquisition_command_decoder_unit");
		else
			$display("FAIL acquisition_command_decoder_unit");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/acd_pkg.sv
hw/rtl/acd_if.sv
hw/rtl/acquisition_command_decoder_unit.sv
verif/acd_decoder_checker.sv
verif/acquisition_command_decoder_unit_tb.sv
